// ===== hdl/bwms_pkg.sv =====
// ----------------------------------------------------------------------------
// bwms_pkg
// Shared types and constants for the bounded window max subarray sum block.
// ----------------------------------------------------------------------------
`default_nettype none

package bwms_pkg;

  localparam int PREFIX_W        = 32;
  localparam int POS_W           = 20;
  localparam int OUT_W           = 18;
  localparam int WIN_W           = 9;
  localparam int OUT_TDATA_W     = 40;
  localparam int WINDOW_MAX_DEF  = 256;
  localparam int SAMPLE_BITS_DEF = 10;

  // One chain entry: an earlier prefix sum and the position it was taken at.
  typedef struct packed {
    logic                valid;
    logic [PREFIX_W-1:0] prefix;
    logic [POS_W-1:0]    pos;
  } entry_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_PUSH,
    OP_SHIFT
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_TRIM
  } state_t;

  // Broadcast from the sequencer to every cell.
  typedef struct packed {
    op_t                 op;
    logic                clear;
    logic                full;
    logic [PREFIX_W-1:0] p_ref;
    logic [POS_W-1:0]    new_pos;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/bwms_cell.sv =====
// ----------------------------------------------------------------------------
// bwms_cell
// One slot of the monotonic chain: holds an entry, drops it when dominated,
// takes the new entry at the end of the kept run, or shifts toward the front.
// ----------------------------------------------------------------------------
`default_nettype none

module bwms_cell (
  input  logic                clk,
  input  logic                rst,
  input  bwms_pkg::cell_ctrl_t ctrl,
  input  logic                left_keep,
  input  bwms_pkg::entry_t    right_entry,
  output bwms_pkg::entry_t    cell_out,
  output logic                keep
);
  import bwms_pkg::*;

  logic                valid;
  logic [PREFIX_W-1:0] prefix;
  logic [POS_W-1:0]    pos;
  logic                valid_next;
  logic [PREFIX_W-1:0] prefix_next;
  logic [POS_W-1:0]    pos_next;
  logic [PREFIX_W-1:0] diff;

  // Keep only entries strictly below the reference prefix (wrapped compare).
  assign diff = prefix - ctrl.p_ref;
  assign keep = valid & ~ctrl.clear & diff[PREFIX_W-1];

  assign cell_out = '{valid: valid, prefix: prefix, pos: pos};

  always_comb begin
    valid_next  = valid;
    prefix_next = prefix;
    pos_next    = pos;
    unique case (ctrl.op)
      OP_PUSH: begin
        if (ctrl.full) begin
          valid_next  = right_entry.valid;
          prefix_next = right_entry.prefix;
          pos_next    = right_entry.pos;
        end else if (keep) begin
          valid_next = 1'b1;
        end else if (left_keep) begin
          valid_next  = 1'b1;
          prefix_next = ctrl.p_ref;
          pos_next    = ctrl.new_pos;
        end else begin
          valid_next = 1'b0;
        end
      end
      OP_SHIFT: begin
        valid_next  = right_entry.valid;
        prefix_next = right_entry.prefix;
        pos_next    = right_entry.pos;
      end
      default: begin
        valid_next = valid;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    prefix <= prefix_next;
    pos    <= pos_next;
  end

endmodule

`default_nettype wire

// ===== hdl/bounded_window_max_subarray_sum.sv =====
// ----------------------------------------------------------------------------
// bounded_window_max_subarray_sum
// Length-limited maximum subarray sum over a stream of signed samples.
// ----------------------------------------------------------------------------
// Each accepted item carries one sample; s_tuser set starts a new sequence.
// The block returns, per item, the best sum of a subarray of 1..window_len
// samples ending at that sample, and the running maximum of that value since
// the sequence began. Earlier prefix sums live in a row of WINDOW_MAX cells
// kept in increasing order with the front at cell 0. An item first pops
// dominated entries and pushes in parallel across the cells, then drops,
// one at a time, each front entry that has fallen out of the window
// (normally 0 or 1, more after window_len shrinks), and loads the output
// register once that register is empty or being read. The next item is
// taken while a result still waits in the output register. window_len is
// clamped to 1..WINDOW_MAX and should be written only while the block is
// idle. A WINDOW_MAX above 511 lowers that upper bound to 511.
`default_nettype none

module bounded_window_max_subarray_sum #(
  parameter int WINDOW_MAX  = bwms_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = bwms_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [bwms_pkg::WIN_W-1:0]           cfg_wdata,    // window_len
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,      // sample
  input  logic                                 s_tuser,      // start_req
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [bwms_pkg::OUT_TDATA_W-1:0]     m_tdata       // ending_best, running_best
);
  import bwms_pkg::*;

  localparam int                 CapInt = (WINDOW_MAX > 511) ? 511 : WINDOW_MAX;
  localparam logic [WIN_W-1:0]   WinCap = WIN_W'(CapInt);
  localparam int                 PadW   = OUT_TDATA_W - 2 * OUT_W;
  localparam logic [OUT_W-1:0]   OutMin = {1'b1, {(OUT_W-1){1'b0}}};
  localparam logic [OUT_W-1:0]   OutMax = {1'b0, {(OUT_W-1){1'b1}}};

  state_t              state;
  state_t              state_next;
  logic [WIN_W-1:0]    win_reg;
  logic [WIN_W-1:0]    win_eff;
  logic [PREFIX_W-1:0] prefix_total;
  logic [POS_W-1:0]    position;
  logic signed [OUT_W-1:0] best;

  logic                       accept;
  logic                       drop;
  logic                       finish;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic [PREFIX_W-1:0]        sample_ext;
  logic [PREFIX_W-1:0]        p_eff;
  logic [POS_W-1:0]           age;
  logic [PREFIX_W-1:0]        diff;
  logic signed [OUT_W-1:0]    ending;
  logic signed [OUT_W-1:0]    best_new;

  cell_ctrl_t             ctrl;
  entry_t                 tail_entry;
  entry_t                 cell_entry [WINDOW_MAX];
  logic [WINDOW_MAX-1:0]  cell_keep;
  logic [WINDOW_MAX-1:0]  cell_valid;
  logic [WINDOW_MAX:0]    valid_ext;
  logic [PREFIX_W-1:0]    tail_diff;
  logic                   tail_full;

  // Window length register.
  always_ff @(posedge clk) begin
    if (rst) begin
      win_reg <= WIN_W'(1);
    end else if (cfg_we) begin
      win_reg <= cfg_wdata;
    end
  end

  always_comb begin
    if (win_reg == '0) begin
      win_eff = WIN_W'(1);
    end else if (win_reg > WinCap) begin
      win_eff = WinCap;
    end else begin
      win_eff = win_reg;
    end
  end

  assign sample_in  = s_tdata[SAMPLE_BITS-1:0];
  assign sample_ext = PREFIX_W'(sample_in);
  assign p_eff      = s_tuser ? '0 : prefix_total;

  // Chain of cells.
  assign valid_ext = {1'b0, cell_valid};
  assign tail_entry = (ctrl.op == OP_PUSH)
                    ? '{valid: 1'b1, prefix: ctrl.p_ref, pos: ctrl.new_pos}
                    : '{valid: 1'b0, prefix: '0, pos: '0};

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    entry_t right_in;
    logic   left_in;
    if (i == WINDOW_MAX - 1) begin : g_last
      assign right_in = tail_entry;
    end else begin : g_mid
      assign right_in = cell_entry[i+1];
    end
    if (i == 0) begin : g_first
      assign left_in = 1'b1;
    end else begin : g_rest
      assign left_in = cell_keep[i-1];
    end
    bwms_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .left_keep  (left_in),
      .right_entry(right_in),
      .cell_out   (cell_entry[i]),
      .keep       (cell_keep[i])
    );
    assign cell_valid[i] = cell_entry[i].valid;
  end

  // Chain is full when the tail cell stays; taken from the registered tail entry.
  assign tail_diff = cell_entry[WINDOW_MAX-1].prefix - p_eff;
  assign tail_full = cell_valid[WINDOW_MAX-1] & ~s_tuser & tail_diff[PREFIX_W-1];

  // Front age and result arithmetic.
  assign age  = position - cell_entry[0].pos;
  assign diff = prefix_total - cell_entry[0].prefix;

  always_comb begin
    if (diff[PREFIX_W-1:OUT_W-1] == '0 || diff[PREFIX_W-1:OUT_W-1] == '1) begin
      ending = diff[OUT_W-1:0];
    end else if (diff[PREFIX_W-1]) begin
      ending = OutMin;
    end else begin
      ending = OutMax;
    end
  end

  assign best_new = (ending > best) ? ending : best;

  // Sequencer: next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_TRIM;
        end
      end
      ST_TRIM: begin
        if (finish) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    s_tready = 1'b0;
    drop     = 1'b0;
    finish   = 1'b0;
    ctrl     = '{op: OP_HOLD, clear: 1'b0, full: 1'b0, p_ref: p_eff,
                 new_pos: (s_tuser ? '0 : position)};
    unique case (state)
      ST_IDLE: begin
        s_tready  = 1'b1;
        if (s_tvalid) begin
          ctrl.op    = OP_PUSH;
          ctrl.clear = s_tuser;
          ctrl.full  = tail_full;
        end
      end
      ST_TRIM: begin
        // Drop one stale front entry per cycle; the newest entry always stays.
        drop   = valid_ext[1] && (age >= POS_W'(win_eff));
        finish = !drop && (!m_tvalid || m_tready);
        if (drop) begin
          ctrl.op = OP_SHIFT;
        end
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  assign accept = s_tvalid & s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      prefix_total <= '0;
      position     <= '0;
      best         <= OutMin;
    end else begin
      state <= state_next;
      if (accept) begin
        prefix_total <= p_eff + sample_ext;
        if (s_tuser) begin
          position <= '0;
          best     <= OutMin;
        end
      end else if (finish) begin
        position <= position + POS_W'(1);
        best     <= best_new;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      m_tdata <= {{PadW{1'b0}}, best_new, ending};
    end
  end

  // Checks.
  a_push_fills_front: assert property (@(posedge clk) disable iff (rst)
    accept |=> cell_valid[0])
    else $error("front cell empty after push");

  a_drop_keeps_front: assert property (@(posedge clk) disable iff (rst)
    drop |=> cell_valid[0])
    else $error("front cell empty after drop");

  a_result_from_trim: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_TRIM)
    else $error("result raised outside trim step");

  a_running_ge_ending: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $signed(m_tdata[2*OUT_W-1:OUT_W]) >= $signed(m_tdata[OUT_W-1:0]))
    else $error("running best below ending best");

  a_tail_full_match: assert property (@(posedge clk) disable iff (rst)
    accept |-> tail_full == cell_keep[WINDOW_MAX-1])
    else $error("chain full flag disagrees with tail cell");

endmodule

`default_nettype wire

// ===== tb/sv/bwms_result_check.sv =====
// ----------------------------------------------------------------------------
// bwms_result_check
// Watches the sample and result streams of the windowed max subarray sum
// block. It keeps its own prefix sums and start-point chain and works out
// the two sums for every accepted item. Each returned item is then compared
// field by field with the oldest sum still due. Window writes are tracked
// from the config port.
// ----------------------------------------------------------------------------
module bwms_result_check #(
  parameter int WINDOW_MAX  = bwms_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = bwms_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [bwms_pkg::WIN_W-1:0]           cfg_wdata,
  input  logic                                 s_tvalid,
  input  logic                                 s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,
  input  logic                                 s_tuser,
  input  logic                                 m_tvalid,
  input  logic                                 m_tready,
  input  logic [bwms_pkg::OUT_TDATA_W-1:0]     m_tdata,
  output int                                   sums_pending,
  output int                                   sum_errors
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PREFIX_W  = bwms_pkg::PREFIX_W;
  localparam int POS_W     = bwms_pkg::POS_W;
  localparam int OUT_W     = bwms_pkg::OUT_W;
  localparam int OUT_MAX   = 2**(OUT_W-1) - 1;
  localparam int OUT_MIN   = -(2**(OUT_W-1));
  localparam int DUE_DEPTH = 16;

  // ending_best in the low bits, running_best above it
  typedef struct packed {
    logic [OUT_W-1:0] running;
    logic [OUT_W-1:0] ending;
  } best_pair_t;

  logic [PREFIX_W-1:0]       prefix_acc;
  logic [POS_W-1:0]          pos_ctr;
  logic [PREFIX_W-1:0]       chain_prefix [WINDOW_MAX];
  logic [POS_W-1:0]          chain_pos [WINDOW_MAX];
  int                        chain_count;
  logic signed [OUT_W-1:0]   seq_best;
  logic [bwms_pkg::WIN_W-1:0] window_len;
  best_pair_t                best_sums_due [DUE_DEPTH];
  int                        due_rd;
  int                        due_wr;
  int                        due_count;
  int                        err_count = 0;

  assign sum_errors = err_count;

  // shift the chain one slot toward the front
  task automatic drop_oldest();
    for (int k = 0; k + 1 < chain_count; k++) begin
      chain_prefix[k] = chain_prefix[k+1];
      chain_pos[k]    = chain_pos[k+1];
    end
    chain_count--;
  endtask

  task automatic compute_window_best(input logic [SAMPLE_BITS-1:0] smp, input logic start,
                                     output best_pair_t res);
    int unsigned             span;
    logic [POS_W-1:0]        age;
    logic signed [PREFIX_W-1:0] sum_val;
    logic signed [OUT_W-1:0] ending;
    span = (window_len == 0) ? 1 : (window_len > WINDOW_MAX) ? WINDOW_MAX : window_len;
    if (start) begin
      prefix_acc  = '0;
      pos_ctr     = '0;
      chain_count = 0;
      seq_best    = OUT_W'(OUT_MIN);
    end
    // drop tail entries not below the prefix before this sample
    while (chain_count > 0 &&
           $signed(chain_prefix[chain_count-1] - prefix_acc) >= 0) begin
      chain_count--;
    end
    if (chain_count >= WINDOW_MAX) drop_oldest();
    chain_prefix[chain_count] = prefix_acc;
    chain_pos[chain_count]    = pos_ctr;
    chain_count++;
    // drop every front start point that has left the window
    while (chain_count > 1) begin
      age = pos_ctr - chain_pos[0];
      if (age < span) break;
      drop_oldest();
    end
    prefix_acc = prefix_acc + {{(PREFIX_W-SAMPLE_BITS){smp[SAMPLE_BITS-1]}}, smp};
    sum_val = prefix_acc - chain_prefix[0];
    if (sum_val > OUT_MAX)
      ending = OUT_W'(OUT_MAX);
    else if (sum_val < OUT_MIN)
      ending = OUT_W'(OUT_MIN);
    else
      ending = sum_val[OUT_W-1:0];
    if (ending > seq_best) seq_best = ending;
    pos_ctr = pos_ctr + 1'b1;
    res.ending  = ending;
    res.running = seq_best;
  endtask

  always @(posedge clk) begin
    best_pair_t want, got;
    if (rst) begin
      prefix_acc  = '0;
      pos_ctr     = '0;
      chain_count = 0;
      seq_best    = OUT_W'(OUT_MIN);
      window_len  = 1;
      due_rd      = 0;
      due_wr      = 0;
      due_count   = 0;
      sums_pending <= 0;
    end else begin
      if (cfg_we) window_len = cfg_wdata;
      if (m_tvalid && m_tready) begin
        got = m_tdata[2*OUT_W-1:0];
        if (due_count == 0) begin
          if (err_count < 10)
            $display("%0t: result item with none due: ending_best %0d running_best %0d",
                     $time, $signed(got.ending), $signed(got.running));
          err_count++;
        end else begin
          want = best_sums_due[due_rd];
          due_rd = (due_rd + 1) % DUE_DEPTH;
          due_count--;
          if (got.ending !== want.ending || got.running !== want.running) begin
            if (err_count < 10)
              $display("%0t: ending_best exp %0d got %0d, running_best exp %0d got %0d",
                       $time, $signed(want.ending), $signed(got.ending),
                       $signed(want.running), $signed(got.running));
            err_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        compute_window_best(s_tdata[SAMPLE_BITS-1:0], s_tuser, want);
        if (due_count == DUE_DEPTH) begin
          if (err_count < 10)
            $display("%0t: too many items accepted without a result", $time);
          err_count++;
        end else begin
          best_sums_due[due_wr] = want;
          due_wr = (due_wr + 1) % DUE_DEPTH;
          due_count++;
        end
      end
      sums_pending <= due_count;
    end
  end

endmodule

// ===== tb/sv/tb_bounded_window_max_subarray_sum.sv =====
// ----------------------------------------------------------------------------
// tb_bounded_window_max_subarray_sum
// Stimulus and verdict for the windowed max subarray sum block.
// ----------------------------------------------------------------------------
// A short directed run covers sample extremes, window clamping and a window
// shrink mid-sequence. Random phases then use different window lengths and
// sample mixes, including a long rising run that fills the start-point chain.
// Both stream sides idle at random; the output side also holds off twice for a
// long stretch so that the block backs up into its input.
module tb_bounded_window_max_subarray_sum;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_BITS = bwms_pkg::SAMPLE_BITS_DEF;
  localparam int WINDOW_MAX  = bwms_pkg::WINDOW_MAX_DEF;
  localparam int TDATA_IN_W  = ((SAMPLE_BITS+7)/8)*8;
  localparam int SMP_MAX     = 2**(SAMPLE_BITS-1) - 1;
  localparam int SMP_MIN     = -(2**(SAMPLE_BITS-1));
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int LONG_HOLD   = 300;

  typedef enum int {
    MIX_FULL,
    MIX_EXTREME,
    MIX_SMALL,
    MIX_RISING,
    MIX_FALLING
  } sample_mix_t;

  logic                             clk = 1'b0;
  logic                             rst;
  logic                             cfg_we;
  logic [bwms_pkg::WIN_W-1:0]       cfg_wdata;
  logic                             s_tvalid;
  logic                             s_tready;
  logic [TDATA_IN_W-1:0]            s_tdata;    // sample
  logic                             s_tuser;    // start_req
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [bwms_pkg::OUT_TDATA_W-1:0] m_tdata;    // ending_best, running_best
  int                               sums_pending;
  int                               sum_errors;
  int                               cycle_count = 0;
  bit                               hold_req;
  bit                               hold_seen;
  bit                               rx_calm;
  int                               stall_left;
  int                               mode_left;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  bounded_window_max_subarray_sum i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  bwms_result_check i_result_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .sums_pending (sums_pending),
    .sum_errors   (sum_errors)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_bounded_window_max_subarray_sum failed");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int rand_gap();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  function automatic int pick_sample(sample_mix_t mix);
    case (mix)
      MIX_EXTREME: return $urandom_range(0, 1) ? SMP_MAX : SMP_MIN;
      MIX_SMALL:   return int'($urandom_range(0, 16)) - 8;
      MIX_RISING:  return $urandom_range(1, SMP_MAX);
      MIX_FALLING: return -int'($urandom_range(0, -SMP_MIN));
      default:     return int'($urandom_range(0, SMP_MAX - SMP_MIN)) + SMP_MIN;
    endcase
  endfunction

  // Output side: random stalls, calm stretches, and a long hold on request.
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
      hold_seen  <= 1'b0;
      mode_left  <= 0;
      rx_calm    <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode_left <= $urandom_range(20, 120);
        rx_calm   <= ($urandom_range(0, 3) == 0);
      end else begin
        mode_left <= mode_left - 1;
      end
      if (hold_seen != hold_req) begin
        hold_seen  <= hold_req;
        stall_left <= LONG_HOLD;
        m_tready   <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        m_tready   <= 1'b0;
      end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
        stall_left <= rand_gap() - 1;
        m_tready   <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send_sample(input int value, input bit start, input bit eager);
    int gap;
    gap = (eager || $urandom_range(0, 2) != 0) ? 0 : rand_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= {{(TDATA_IN_W-SAMPLE_BITS){1'b0}}, value[SAMPLE_BITS-1:0]};
    s_tuser  <= start;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  // Stop offering and wait for every result still owed.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sums_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_window(input int len);
    drain();
    cfg_wdata <= len[bwms_pkg::WIN_W-1:0];
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    sample_mix_t mix;
    int          win;
    int          n;
    bit          eager;
    bit          start;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = 1'b0;
    hold_req  = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset window, stream begins without a start flag
    send_sample(SMP_MAX, 1'b0, 1'b0);
    send_sample(SMP_MIN, 1'b0, 1'b0);
    send_sample(0, 1'b0, 1'b0);
    send_sample(-1, 1'b0, 1'b0);
    send_sample(1, 1'b1, 1'b0);
    send_sample(SMP_MIN, 1'b0, 1'b0);
    // zero window acts as one
    write_window(0);
    send_sample(SMP_MAX, 1'b1, 1'b0);
    send_sample(3, 1'b0, 1'b0);
    // oversized window clamps
    write_window(511);
    send_sample(SMP_MIN, 1'b1, 1'b0);
    send_sample(SMP_MIN, 1'b0, 1'b0);
    send_sample(SMP_MAX, 1'b0, 1'b0);
    send_sample(SMP_MAX, 1'b0, 1'b0);
    send_sample(SMP_MAX, 1'b0, 1'b0);
    send_sample(-1, 1'b0, 1'b0);
    send_sample(-7, 1'b0, 1'b0);
    // shrink mid-sequence, several front entries go for one sample
    write_window(2);
    send_sample(100, 1'b0, 1'b0);
    send_sample(-5, 1'b0, 1'b0);
    send_sample(7, 1'b0, 1'b0);
    write_window(WINDOW_MAX);
    send_sample(1, 1'b1, 1'b0);
    send_sample(SMP_MIN, 1'b0, 1'b0);
    send_sample(SMP_MAX, 1'b0, 1'b0);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0:       win = WINDOW_MAX;
        1:       win = 1;
        2:       win = 511;
        3:       win = 0;
        default: win = $urandom_range(1, 300);
      endcase
      write_window(win);
      eager = (ph % 3 == 2);
      n     = (ph == 0) ? 320 : 70;
      mix   = (ph == 0) ? MIX_RISING : sample_mix_t'($urandom_range(0, 4));
      for (int i = 0; i < n; i++) begin
        if ((ph == 2 && i == 5) || (ph == 6 && i == 20)) hold_req <= ~hold_req;
        if (ph == 4 && i == 35) drain();
        if (ph != 0 && $urandom_range(0, 29) == 0) mix = sample_mix_t'($urandom_range(0, 4));
        // the rising run must stay one sequence so the chain fills up;
        // phase 1 carries it on so the shrink to one drops every earlier entry
        if (i == 0)
          start = (ph == 0) ? 1'b1 : (ph == 1) ? 1'b0 : ($urandom_range(0, 2) != 0);
        else
          start = (ph != 0) && ($urandom_range(0, 49) == 0);
        send_sample(pick_sample(mix), start, eager);
      end
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sums_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sum_errors == 0)
      $display("tb_bounded_window_max_subarray_sum passed");
    else
      $display("tb_bounded_window_max_subarray_sum failed");
    $finish;
  end

endmodule
